// ----- rtl/ism_pkg.sv -----
// Shared types, constants and a saturating helper for the interval set merge block.
`timescale 1ns / 1ps

package ism_pkg;

  localparam int unsigned MAX_INTERVALS = 64;
  localparam int unsigned DataW = 64;

  localparam logic signed [DataW-1:0] MinVal = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] One = {{(DataW-1){1'b0}}, 1'b1};

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Row-wide command issued to every cell in the same cycle
  typedef struct packed {
    logic merge;   // fold touching cells into the new interval, mark them
    logic insert;  // open a new entry at its sorted place
    logic step;    // collapse one absorbed cell by a left shift
  } ism_op_t;

  // Status a cell shares with its neighbors
  typedef struct packed {
    logic valid;
    logic mark;
    logic sh;
    logic below;
  } ism_cell_st_t;

  // Saturating minus one on signed values
  function automatic logic signed [DataW-1:0] sat_dec(input logic signed [DataW-1:0] x);
    return (x == MinVal) ? x : x - One;
  endfunction

endpackage

// ----- rtl/ism_cell.sv -----
// One storage cell of the interval row: holds an interval and talks to its neighbors.
`timescale 1ns / 1ps

module ism_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ism_pkg::ism_op_t                   op_i,
  input  logic signed [ism_pkg::DataW-1:0]   lo_i,
  input  logic signed [ism_pkg::DataW-1:0]   hi_i,
  input  logic signed [ism_pkg::DataW-1:0]   dec_lo_i,
  input  logic signed [ism_pkg::DataW-1:0]   probe_i,
  input  ism_pkg::ism_cell_st_t              prev_st_i,
  input  logic signed [ism_pkg::DataW-1:0]   prev_low_i,
  input  logic signed [ism_pkg::DataW-1:0]   prev_high_i,
  input  ism_pkg::ism_cell_st_t              next_st_i,
  input  logic signed [ism_pkg::DataW-1:0]   next_low_i,
  input  logic signed [ism_pkg::DataW-1:0]   next_high_i,
  output ism_pkg::ism_cell_st_t              st_o,
  output logic signed [ism_pkg::DataW-1:0]   low_o,
  output logic signed [ism_pkg::DataW-1:0]   high_o,
  output logic                               touch_o,
  output logic                               hit_o,
  output logic                               more_o
);
  import ism_pkg::*;

  logic signed [DataW-1:0] low_q, low_d, high_q, high_d;
  logic valid_q, valid_d, mark_q, mark_d, sh_q, sh_d;
  logic below, touch, head;

  // Compare the broadcast interval and probe against this entry
  assign below   = valid_q && (high_q < dec_lo_i);
  assign touch   = valid_q && !below && !(hi_i < sat_dec(low_q));
  assign hit_o   = valid_q && (probe_i >= low_q) && (probe_i <= high_q);
  assign touch_o = touch;

  // Head of the merged run: last cell that does not shift during compaction
  assign head   = !sh_q && next_st_i.sh;
  assign more_o = head && next_st_i.mark;

  assign st_o   = '{valid: valid_q, mark: mark_q, sh: sh_q, below: below};
  assign low_o  = low_q;
  assign high_o = high_q;

  // Pick the next cell contents for the current row command
  always_comb begin
    low_d   = low_q;
    high_d  = high_q;
    valid_d = valid_q;
    mark_d  = mark_q;
    sh_d    = sh_q;
    if (op_i.merge) begin
      if (touch) begin
        low_d  = (lo_i < low_q) ? lo_i : low_q;
        high_d = (hi_i > high_q) ? hi_i : high_q;
      end
      mark_d = touch;
      sh_d   = !below && !(touch && prev_st_i.below);
    end else if (op_i.insert) begin
      if (!below) begin
        if (prev_st_i.below) begin
          low_d   = lo_i;
          high_d  = hi_i;
          valid_d = 1'b1;
        end else begin
          low_d   = prev_low_i;
          high_d  = prev_high_i;
          valid_d = prev_st_i.valid;
        end
      end
    end else if (op_i.step) begin
      if (sh_q) begin
        low_d   = next_low_i;
        high_d  = next_high_i;
        valid_d = next_st_i.valid;
        mark_d  = next_st_i.mark;
      end else if (head) begin
        high_d = (next_high_i > high_q) ? next_high_i : high_q;
      end
    end
  end

  // Hold control bits under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      mark_q  <= 1'b0;
      sh_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      mark_q  <= mark_d;
      sh_q    <= sh_d;
    end
  end

  // Hold interval bounds
  always_ff @(posedge clk_i) begin
    low_q  <= low_d;
    high_q <= high_d;
  end

endmodule

// ----- rtl/interval_set_merge.sv -----
// Top level of the interval set merge block: command control over a row of cells.
// A query, a dropped or reversed insert, or an insert opening a new entry shows its
//   result strobe from the evaluate state; new items are accepted only when idle.
// An insert that merges stored entries strobes when the compaction state finishes,
//   which shifts the row one position per cycle while an absorbed cell remains.
// Reset clears the count and all cell valid bits; the receiver cannot stall a result.
`timescale 1ns / 1ps

module interval_set_merge #(
  parameter int unsigned MaxIntervals = ism_pkg::MAX_INTERVALS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command_i,
  input  logic signed [ism_pkg::DataW-1:0]  range_low_i,
  input  logic signed [ism_pkg::DataW-1:0]  range_high_i,
  input  logic signed [ism_pkg::DataW-1:0]  probe_value_i,
  output logic                              done_o,
  output logic                              found_o,
  output logic                              table_full_o,
  output logic [6:0]                        entry_count_o
);
  import ism_pkg::*;

  localparam int unsigned CntW = $clog2(MaxIntervals + 1);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_EVAL    = 2'd1;
  localparam logic [1:0] S_COMPACT = 2'd2;

  logic [1:0] state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic done_q, done_d, found_q, found_d, full_q, full_d;
  logic cmd_q;
  logic signed [DataW-1:0] lo_q, hi_q, probe_q, dec_lo;
  ism_op_t op;

  ism_cell_st_t            cell_st   [MaxIntervals];
  logic signed [DataW-1:0] cell_low  [MaxIntervals];
  logic signed [DataW-1:0] cell_high [MaxIntervals];
  logic [MaxIntervals-1:0] touch_vec, hit_vec, more_vec;
  logic accept, any_touch, reversed;
  logic [CntW+6:0] count_ext;

  assign accept    = start && !busy;
  assign dec_lo    = sat_dec(lo_q);
  assign any_touch = |touch_vec;
  assign reversed  = lo_q > hi_q;

  // Row of interval cells
  for (genvar e = 0; e < MaxIntervals; e++) begin : g_cell
    ism_cell_st_t            prev_st, next_st;
    logic signed [DataW-1:0] prev_low, prev_high, next_low, next_high;

    if (e == 0) begin : g_first
      assign prev_st   = '{valid: 1'b0, mark: 1'b0, sh: 1'b0, below: 1'b1};
      assign prev_low  = '0;
      assign prev_high = '0;
    end else begin : g_mid_prev
      assign prev_st   = cell_st[e-1];
      assign prev_low  = cell_low[e-1];
      assign prev_high = cell_high[e-1];
    end

    if (e == MaxIntervals - 1) begin : g_last
      assign next_st   = '{valid: 1'b0, mark: 1'b0, sh: 1'b1, below: 1'b0};
      assign next_low  = '0;
      assign next_high = '0;
    end else begin : g_mid_next
      assign next_st   = cell_st[e+1];
      assign next_low  = cell_low[e+1];
      assign next_high = cell_high[e+1];
    end

    ism_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .lo_i        (lo_q),
      .hi_i        (hi_q),
      .dec_lo_i    (dec_lo),
      .probe_i     (probe_q),
      .prev_st_i   (prev_st),
      .prev_low_i  (prev_low),
      .prev_high_i (prev_high),
      .next_st_i   (next_st),
      .next_low_i  (next_low),
      .next_high_i (next_high),
      .st_o        (cell_st[e]),
      .low_o       (cell_low[e]),
      .high_o      (cell_high[e]),
      .touch_o     (touch_vec[e]),
      .hit_o       (hit_vec[e]),
      .more_o      (more_vec[e])
    );
  end

  // Sequence one transaction: evaluate, then compact merged cells
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    done_d  = 1'b0;
    found_d = found_q;
    full_d  = full_q;
    op      = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        found_d = 1'b0;
        full_d  = 1'b0;
        if (cmd_q == CMD_QUERY) begin
          found_d = |hit_vec;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (reversed) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (any_touch) begin
          op.merge = 1'b1;
          state_d  = S_COMPACT;
        end else if (count_q == CntW'(MaxIntervals)) begin
          full_d  = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          op.insert = 1'b1;
          count_d   = count_q + CntW'(1);
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_COMPACT: begin
        if (|more_vec) begin
          op.step = 1'b1;
          count_d = count_q - CntW'(1);
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Advance control and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      found_q <= found_d;
      full_q  <= full_d;
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_i;
      lo_q    <= range_low_i;
      hi_q    <= range_high_i;
      probe_q <= probe_value_i;
    end
  end

  assign count_ext     = {7'b0, count_q};
  assign busy          = state_q != S_IDLE;
  assign done_o        = done_q;
  assign found_o       = found_q;
  assign table_full_o  = full_q;
  assign entry_count_o = count_ext[6:0];

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy)
    else $error("accepted transaction did not start work");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !(found_o && table_full_o))
    else $error("found and table_full both set");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(MaxIntervals))
    else $error("entry count above capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_COMPACT && |more_vec) |=> $past(count_q) == count_q + CntW'(1))
    else $error("compaction step did not drop one entry");

endmodule
